@@ hw/rtl/spi_adc_dust_read_sequencer_assert.svh @@
// Assertion macros for the dust sensor read sequencer.
// Each property is clocked on clk and disabled while rst_n is low.
`ifndef SPI_ADC_DUST_READ_SEQUENCER_ASSERT_SVH
`define SPI_ADC_DUST_READ_SEQUENCER_ASSERT_SVH

`ifndef SYNTH

// Consequent must hold in the same cycle as the antecedent.
`define SADS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sads assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SADS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sads assertion failed");

`else

`define SADS_ASSERT_NOW(lbl, ante, cons)
`define SADS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ hw/rtl/sads_pkg.sv @@
package sads_pkg;

  // Converter command layout
  localparam int CHANNEL_BITS = 3;
  localparam int CHAN_W       = 3;
  localparam int TX_W         = 8;
  localparam logic [TX_W-1:0] TX_START = 8'hC0;
  localparam logic [TX_W-1:0] CHAN_MASK = TX_W'((1 << CHANNEL_BITS) - 1);
  localparam int CHAN_SHIFT   = 6 - CHANNEL_BITS;

  // Sequence sizes
  localparam int TICK_W       = 20;
  localparam int BIT_W        = 5;
  localparam logic [BIT_W-1:0] TOTAL_BITS = 5'd24;
  localparam int SAMPLE_W     = 10;
  localparam int SAMPLE_LSB   = 7;
  localparam int RX_W         = SAMPLE_LSB + SAMPLE_W;

  // Configuration registers
  localparam int PHASE_W      = 10;
  localparam int CHARGE_W     = 20;
  localparam int SETTLE_W     = 10;
  localparam int CFG_ADDR_W   = 2;
  localparam int CFG_DATA_W   = 20;

  localparam logic [CFG_ADDR_W-1:0] REG_PHASE_TICKS  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CHARGE_TICKS = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SETTLE_TICKS = 2'd2;

  localparam logic [PHASE_W-1:0]  PHASE_TICKS_RST  = 10'd10;
  localparam logic [CHARGE_W-1:0] CHARGE_TICKS_RST = 20'd100000;
  localparam logic [SETTLE_W-1:0] SETTLE_TICKS_RST = 10'd28;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_CHARGE = 3'd1,
    PH_SETTLE = 3'd2,
    PH_SETUP  = 3'd3,
    PH_HIGH   = 3'd4,
    PH_LOW    = 3'd5
  } phase_t;

  typedef struct packed {
    logic                sclk;
    logic                mosi;
    logic                cs_n;
    logic                led;
    logic                busy_res;
    logic                done_res;
    logic [SAMPLE_W-1:0] sample;
  } res_t;

endpackage

@@ hw/rtl/sads_if.sv @@
interface sads_in_if;
  logic                         valid;
  logic                         ready;
  logic                         start_req;
  logic [sads_pkg::CHAN_W-1:0]  channel;
  logic                         miso;

  modport source (output valid, output start_req, output channel, output miso,
                  input ready);
  modport sink (input valid, input start_req, input channel, input miso,
                output ready);
endinterface

interface sads_out_if;
  logic                          valid;
  logic                          ready;
  logic                          sclk;
  logic                          mosi;
  logic                          cs_n;
  logic                          led;
  logic                          busy_res;
  logic                          done_res;
  logic [sads_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sclk, output mosi, output cs_n, output led,
                  output busy_res, output done_res, output sample, input ready);
  modport sink (input valid, input sclk, input mosi, input cs_n, input led,
                input busy_res, input done_res, input sample, output ready);
endinterface

interface sads_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sads_pkg::CFG_ADDR_W-1:0] addr;
  logic [sads_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

@@ hw/rtl/spi_adc_dust_read_sequencer.sv @@
// Each accepted tick item has its result item registered in the output register.
// Throughput: one item per cycle while the output is not stalled; the sequencer state advances once per accepted item.
// The sequencer state register loop is closed through one step of next-state logic.
// Reset (rst_n low, synchronous): idle, cs_n state high, other pin states low, sample zero,
// tick registers back to 10 / 100000 / 28, no result pending.
`include "spi_adc_dust_read_sequencer_assert.svh"

module spi_adc_dust_read_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  sads_in_if.sink     in_ch,
  sads_out_if.source  out_ch,
  sads_cfg_if.sink    cfg_ch
);

  // Configuration registers
  logic [sads_pkg::PHASE_W-1:0]  phase_ticks_r;
  logic [sads_pkg::CHARGE_W-1:0] charge_ticks_r;
  logic [sads_pkg::SETTLE_W-1:0] settle_ticks_r;

  // Sequencer state
  sads_pkg::phase_t              phase_r, phase_nxt;
  logic [sads_pkg::TICK_W-1:0]   tick_r, tick_nxt;
  logic [sads_pkg::BIT_W-1:0]    bit_r, bit_nxt, bit_inc;
  logic [sads_pkg::TX_W-1:0]     tx_r, tx_nxt;
  logic [sads_pkg::RX_W-1:0]     rx_r, rx_nxt;
  logic                          sclk_r, sclk_nxt;
  logic                          mosi_r, mosi_nxt;
  logic                          csn_r, csn_nxt;
  logic                          led_r, led_nxt;
  logic [sads_pkg::SAMPLE_W-1:0] sample_r, sample_nxt;
  logic                          done_nxt;

  // Result register
  sads_pkg::res_t                out_r, res_nxt;
  logic                          out_valid_r, out_valid_nxt;

  logic                          in_acc;
  logic                          is_idle;
  logic                          start_go;
  logic [sads_pkg::TICK_W-1:0]   phase_load, charge_load, settle_load;

  // Take a new item whenever the result register is empty or being drained.
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // A start request only counts in idle; drop it while busy.
  assign is_idle  = (phase_r == sads_pkg::PH_IDLE);
  assign start_go = in_acc && is_idle && in_ch.start_req;

  // A stage lasts its register's count of ticks; zero counts as one tick.
  assign phase_load  = (phase_ticks_r == '0) ? '0
                     : sads_pkg::TICK_W'(phase_ticks_r - 1'b1);
  assign charge_load = (charge_ticks_r == '0) ? '0 : charge_ticks_r - 1'b1;
  assign settle_load = (settle_ticks_r == '0) ? '0
                     : sads_pkg::TICK_W'(settle_ticks_r - 1'b1);

  assign bit_inc = bit_r + 1'b1;

  // Configuration writes; an address beyond the register list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r  <= sads_pkg::PHASE_TICKS_RST;
      charge_ticks_r <= sads_pkg::CHARGE_TICKS_RST;
      settle_ticks_r <= sads_pkg::SETTLE_TICKS_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.addr)
        sads_pkg::REG_PHASE_TICKS:  phase_ticks_r  <= cfg_ch.data[sads_pkg::PHASE_W-1:0];
        sads_pkg::REG_CHARGE_TICKS: charge_ticks_r <= cfg_ch.data[sads_pkg::CHARGE_W-1:0];
        sads_pkg::REG_SETTLE_TICKS: settle_ticks_r <= cfg_ch.data[sads_pkg::SETTLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer next state: one step per accepted tick.
  always_comb begin
    phase_nxt  = phase_r;
    tick_nxt   = tick_r;
    bit_nxt    = bit_r;
    tx_nxt     = tx_r;
    rx_nxt     = rx_r;
    sclk_nxt   = sclk_r;
    mosi_nxt   = mosi_r;
    csn_nxt    = csn_r;
    led_nxt    = led_r;
    sample_nxt = sample_r;
    done_nxt   = 1'b0;

    if (start_go) begin
      // Start: load the command byte, hold LED low to charge.
      tx_nxt    = sads_pkg::TX_START
                | ((sads_pkg::TX_W'(in_ch.channel) & sads_pkg::CHAN_MASK)
                   << sads_pkg::CHAN_SHIFT);
      rx_nxt    = '0;
      bit_nxt   = '0;
      sclk_nxt  = 1'b0;
      mosi_nxt  = 1'b1;
      led_nxt   = 1'b0;
      csn_nxt   = 1'b1;
      phase_nxt = sads_pkg::PH_CHARGE;
      tick_nxt  = charge_load;
    end else if (in_acc && !is_idle) begin
      if (tick_r != '0) begin
        tick_nxt = tick_r - 1'b1;
      end else begin
        unique case (phase_r)
          sads_pkg::PH_CHARGE: begin
            // LED on, select the converter, wait for it to settle.
            led_nxt   = 1'b1;
            csn_nxt   = 1'b0;
            phase_nxt = sads_pkg::PH_SETTLE;
            tick_nxt  = settle_load;
          end
          sads_pkg::PH_SETTLE: begin
            mosi_nxt  = tx_r[sads_pkg::TX_W-1];
            phase_nxt = sads_pkg::PH_SETUP;
            tick_nxt  = phase_load;
          end
          sads_pkg::PH_SETUP: begin
            // Clock high and sample MISO on the first tick of the phase.
            sclk_nxt  = 1'b1;
            rx_nxt    = {rx_r[sads_pkg::RX_W-2:0], in_ch.miso};
            phase_nxt = sads_pkg::PH_HIGH;
            tick_nxt  = phase_load;
          end
          sads_pkg::PH_HIGH: begin
            sclk_nxt  = 1'b0;
            phase_nxt = sads_pkg::PH_LOW;
            tick_nxt  = phase_load;
          end
          sads_pkg::PH_LOW: begin
            tx_nxt = tx_r << 1;
            if (bit_inc >= sads_pkg::TOTAL_BITS) begin
              // Last bit done: release the converter, LED off, report.
              csn_nxt    = 1'b1;
              led_nxt    = 1'b0;
              sample_nxt = rx_r[sads_pkg::RX_W-1:sads_pkg::SAMPLE_LSB];
              done_nxt   = 1'b1;
              phase_nxt  = sads_pkg::PH_IDLE;
              tick_nxt   = '0;
              bit_nxt    = '0;
            end else begin
              bit_nxt   = bit_inc;
              mosi_nxt  = tx_r[sads_pkg::TX_W-2];
              phase_nxt = sads_pkg::PH_SETUP;
              tick_nxt  = phase_load;
            end
          end
          default: ;
        endcase
      end
    end

    res_nxt.sclk     = sclk_nxt;
    res_nxt.mosi     = mosi_nxt;
    res_nxt.cs_n     = csn_nxt;
    res_nxt.led      = led_nxt;
    res_nxt.busy_res = (phase_nxt != sads_pkg::PH_IDLE);
    res_nxt.done_res = done_nxt;
    res_nxt.sample   = sample_nxt;

    // Hold a waiting result; drop it once taken.
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= sads_pkg::PH_IDLE;
      tick_r      <= '0;
      bit_r       <= '0;
      tx_r        <= '0;
      rx_r        <= '0;
      sclk_r      <= 1'b0;
      mosi_r      <= 1'b0;
      csn_r       <= 1'b1;
      led_r       <= 1'b0;
      sample_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      tick_r      <= tick_nxt;
      bit_r       <= bit_nxt;
      tx_r        <= tx_nxt;
      rx_r        <= rx_nxt;
      sclk_r      <= sclk_nxt;
      mosi_r      <= mosi_nxt;
      csn_r       <= csn_nxt;
      led_r       <= led_nxt;
      sample_r    <= sample_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload: load on every accepted item.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_r <= res_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.sclk     = out_r.sclk;
  assign out_ch.mosi     = out_r.mosi;
  assign out_ch.cs_n     = out_r.cs_n;
  assign out_ch.led      = out_r.led;
  assign out_ch.busy_res = out_r.busy_res;
  assign out_ch.done_res = out_r.done_res;
  assign out_ch.sample   = out_r.sample;

  // Checks
  `SADS_ASSERT_NEXT(a_start_enters_charge, start_go, phase_r == sads_pkg::PH_CHARGE)
  `SADS_ASSERT_NOW(a_idle_no_count, is_idle, (tick_r == '0) && (bit_r == '0))
  `SADS_ASSERT_NOW(a_bit_in_range, !is_idle, bit_r < sads_pkg::TOTAL_BITS)
  `SADS_ASSERT_NOW(a_select_only_busy, out_valid_r && !out_r.cs_n, out_r.busy_res && !out_r.done_res)

endmodule
